[rtl/core/assert_macros.svh]
// Assertion macros shared by the convolution core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[rtl/core/c3s_pkg.sv]
// Types and constants for the 3x3 saturating convolution core.
`timescale 1ns / 1ps
package c3s_pkg;

	localparam int TAPS         = 3;
	localparam int PIX_W        = 8;
	localparam int REG_W        = 48;
	localparam int DIM_REG_W    = 11;
	localparam int DIM_W        = 13;
	localparam int COEF_FIELD_W = 16;
	localparam int CFG_IDX_W    = 3;

	// output queue
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [PIX_W-1:0]     PIX_MAX    = 8'd255;
	localparam logic [DIM_W-1:0]     MIN_DIM    = 13'd3;
	localparam logic [DIM_W-1:0]     WIN_START  = 13'd2;
	localparam logic [REG_W-1:0]     KROW0_RST  = 48'h0;
	localparam logic [REG_W-1:0]     KROW1_RST  = 48'h10000;
	localparam logic [REG_W-1:0]     KROW2_RST  = 48'h0;
	localparam logic [DIM_REG_W-1:0] DIM_RST    = 11'd1024;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KERNEL_ROW0 = 3'd0,
		REG_KERNEL_ROW1 = 3'd1,
		REG_KERNEL_ROW2 = 3'd2,
		REG_LINE_WIDTH  = 3'd3,
		REG_FRAME_LINES = 3'd4
	} reg_idx_t;

	typedef logic [PIX_W-1:0] pix_t;

	// 3x3 neighbourhood, [row][column], column 0 is two pixels back
	typedef pix_t [TAPS-1:0][TAPS-1:0] win_t;

	typedef struct packed {
		logic valid;
		logic frame_end;
	} tag_t;

	typedef struct packed {
		logic frame_end;
		pix_t pixel_out;
	} res_t;

endpackage

[rtl/core/c3s_if.sv]
// Handshake interfaces for the pixel, result and configuration channels.
`timescale 1ns / 1ps
interface c3s_pix_if;
	import c3s_pkg::*;
	logic       valid;
	logic       ready;
	logic [PIX_W-1:0] pixel_in;
	modport source (output valid, output pixel_in, input ready);
	modport sink (input valid, input pixel_in, output ready);
endinterface

interface c3s_res_if;
	import c3s_pkg::*;
	logic       valid;
	logic       ready;
	logic [PIX_W-1:0] pixel_out;
	logic       frame_end;
	modport source (output valid, output pixel_out, output frame_end, input ready);
	modport sink (input valid, input pixel_out, input frame_end, output ready);
endinterface

interface c3s_cfg_if;
	import c3s_pkg::*;
	logic       valid;
	logic       ready;
	logic [CFG_IDX_W-1:0] index;
	logic [REG_W-1:0]     data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/core/conv3x3_saturating_stream.sv]
// Top level of the 3x3 saturating convolution core over a raster pixel stream.
// A result passes the stage registers s1 to s4 and the result queue before it is offered.
// Throughput: one pixel per cycle while the result queue has room, set by the one read and one write per pixel
// on the line store memory; an 8-word result queue decouples the output side.
// Reset (arst_n low) clears counters, window and queue and loads register defaults;
// the line store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
module conv3x3_saturating_stream #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int COEF_BITS  = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	c3s_cfg_if.sink   cfg,
	c3s_pix_if.sink   pix,
	c3s_res_if.source res
);
	import c3s_pkg::*;

	logic [REG_W-1:0]     krow_q [TAPS];
	logic [DIM_REG_W-1:0] width_q, lines_q;
	logic                 accept, produce, room, push;
	win_t                 win_s1;
	tag_t                 tag_s1;
	res_t                 push_data;
	logic [TAPS-1:0][TAPS-1:0][COEF_BITS-1:0] coefs;

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			krow_q[0] <= KROW0_RST;
			krow_q[1] <= KROW1_RST;
			krow_q[2] <= KROW2_RST;
			width_q   <= DIM_RST;
			lines_q   <= DIM_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_KERNEL_ROW0: krow_q[0] <= cfg.data;
				REG_KERNEL_ROW1: krow_q[1] <= cfg.data;
				REG_KERNEL_ROW2: krow_q[2] <= cfg.data;
				REG_LINE_WIDTH:  width_q   <= cfg.data[DIM_REG_W-1:0];
				REG_FRAME_LINES: lines_q   <= cfg.data[DIM_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// coefficient fields, each narrowed to COEF_BITS
	always_comb begin
		for (int y = 0; y < TAPS; y++) begin
			for (int x = 0; x < TAPS; x++) begin
				coefs[y][x] = krow_q[y][COEF_FIELD_W*x +: COEF_BITS];
			end
		end
	end

	// input handshake
	assign pix.ready = room;
	assign accept    = pix.valid && room;

	c3s_line_buf #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_line_buf (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.pixel       (pix.pixel_in),
		.line_width  (width_q),
		.frame_lines (lines_q),
		.produce     (produce),
		.win_s1      (win_s1),
		.tag_s1      (tag_s1)
	);

	c3s_mac #(
		.COEF_BITS (COEF_BITS)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.win_s1    (win_s1),
		.tag_s1    (tag_s1),
		.coefs     (coefs),
		.push      (push),
		.push_data (push_data)
	);

	c3s_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.reserve   (accept && produce),
		.push      (push),
		.push_data (push_data),
		.room      (room),
		.res       (res)
	);

endmodule

[rtl/core/c3s_line_buf.sv]
// Line store memory, raster counters and 3x3 window registers.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module c3s_line_buf #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  c3s_pkg::pix_t                     pixel,
	input  logic [c3s_pkg::DIM_REG_W-1:0]     line_width,
	input  logic [c3s_pkg::DIM_REG_W-1:0]     frame_lines,
	output logic                              produce,
	output c3s_pkg::win_t                     win_s1,
	output c3s_pkg::tag_t                     tag_s1
);
	import c3s_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam logic [DIM_W-1:0] MAX_W_D = DIM_W'(MAX_WIDTH);
	localparam logic [DIM_W-1:0] MAX_H_D = DIM_W'(MAX_HEIGHT);

	logic [CW-1:0]    col_q, col_nx, addr_s1;
	logic [RW-1:0]    row_q, row_nx;
	logic [DIM_W-1:0] lw_ext, fl_ext, w_d, h_d, col_d, row_d, col_inc, row_inc;
	logic             frame_end_now, acc_s1;
	pix_t             pix_s1, top, mid;
	logic [2*PIX_W-1:0] rd_q;
	pix_t             win_q [TAPS][TAPS-1];

	// word layout: top line in the upper byte, middle line in the lower
	logic [2*PIX_W-1:0] mem [MAX_WIDTH];

	// geometry clamped to the supported range
	assign lw_ext = DIM_W'(line_width);
	assign fl_ext = DIM_W'(frame_lines);
	always_comb begin
		if (lw_ext < MIN_DIM) begin
			w_d = MIN_DIM;
		end else if (lw_ext > MAX_W_D) begin
			w_d = MAX_W_D;
		end else begin
			w_d = lw_ext;
		end
		if (fl_ext < MIN_DIM) begin
			h_d = MIN_DIM;
		end else if (fl_ext > MAX_H_D) begin
			h_d = MAX_H_D;
		end else begin
			h_d = fl_ext;
		end
	end

	assign col_d = DIM_W'(col_q);
	assign row_d = DIM_W'(row_q);

	// result flags for the pixel at the input
	assign produce       = (row_d >= WIN_START) && (col_d >= WIN_START);
	assign frame_end_now = (row_d == h_d - 1'b1) && (col_d == w_d - 1'b1);

	// raster position after this pixel
	always_comb begin
		col_inc = col_d + 1'b1;
		row_inc = row_d + 1'b1;
		if (col_inc >= w_d) begin
			col_nx = '0;
			row_nx = (row_inc >= h_d) ? '0 : row_inc[RW-1:0];
		end else begin
			col_nx = col_inc[CW-1:0];
			row_nx = (row_d >= h_d) ? '0 : row_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			acc_s1 <= 1'b0;
			tag_s1 <= '0;
		end else begin
			acc_s1       <= accept;
			tag_s1.valid <= accept && produce;
			if (accept) begin
				col_q <= col_nx;
				row_q <= row_nx;
				tag_s1.frame_end <= frame_end_now;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1 <= col_q;
			pix_s1  <= pixel;
		end
	end

	// line store: read at accept, write back in the following cycle.
	// The same column recurs no sooner than three pixels on, so the
	// write always lands before the next read of that entry.
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q <= mem[col_q];
		end
	end

	always_ff @(posedge clk) begin
		if (acc_s1) begin
			mem[addr_s1] <= {mid, pix_s1};
		end
	end

	assign top = rd_q[2*PIX_W-1:PIX_W];
	assign mid = rd_q[PIX_W-1:0];

	// window shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int y = 0; y < TAPS; y++) begin
				for (int x = 0; x < TAPS - 1; x++) begin
					win_q[y][x] <= '0;
				end
			end
		end else if (acc_s1) begin
			for (int y = 0; y < TAPS; y++) begin
				win_q[y][0] <= win_q[y][1];
			end
			win_q[0][1] <= top;
			win_q[1][1] <= mid;
			win_q[2][1] <= pix_s1;
		end
	end

	always_comb begin
		for (int y = 0; y < TAPS; y++) begin
			win_s1[y][0] = win_q[y][0];
			win_s1[y][1] = win_q[y][1];
		end
		win_s1[0][2] = top;
		win_s1[1][2] = mid;
		win_s1[2][2] = pix_s1;
	end

	`ASSERT_CLK(a_col_range, clk, arst_n, col_d < MAX_W_D, "column counter out of range")
	`ASSERT_CLK(a_row_range, clk, arst_n, row_d < MAX_H_D, "row counter out of range")
	`ASSERT_IMPL(a_no_raw_clash, clk, arst_n, acc_s1 && accept, addr_s1 != col_q, "line store clash")

endmodule

[rtl/core/c3s_mac.sv]
// Nine-tap multiply and adder tree with saturation to 8 bits.
`timescale 1ns / 1ps
module c3s_mac #(
	parameter int COEF_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  c3s_pkg::win_t win_s1,
	input  c3s_pkg::tag_t tag_s1,
	input  logic [c3s_pkg::TAPS-1:0][c3s_pkg::TAPS-1:0][COEF_BITS-1:0] coefs,
	output logic          push,
	output c3s_pkg::res_t push_data
);
	import c3s_pkg::*;

	localparam int PROD_W = PIX_W + COEF_BITS;
	localparam int ROW_W  = PROD_W + 2;
	localparam int SUM_W  = PROD_W + 4;

	logic [PROD_W-1:0] prod_s2 [TAPS][TAPS];
	logic [ROW_W-1:0]  row_s3 [TAPS];
	logic [SUM_W-1:0]  total;
	tag_t              tag_s2, tag_s3, tag_s4;
	res_t              res_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else begin
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
		end
	end

	// products
	always_ff @(posedge clk) begin
		for (int y = 0; y < TAPS; y++) begin
			for (int x = 0; x < TAPS; x++) begin
				prod_s2[y][x] <= PROD_W'(win_s1[y][x]) * PROD_W'(coefs[y][x]);
			end
		end
	end

	// row sums
	always_ff @(posedge clk) begin
		for (int y = 0; y < TAPS; y++) begin
			row_s3[y] <= ROW_W'(prod_s2[y][0]) + ROW_W'(prod_s2[y][1])
				+ ROW_W'(prod_s2[y][2]);
		end
	end

	// final sum and clip
	assign total = SUM_W'(row_s3[0]) + SUM_W'(row_s3[1]) + SUM_W'(row_s3[2]);

	always_ff @(posedge clk) begin
		res_s4.frame_end <= tag_s3.frame_end;
		if (total > SUM_W'(PIX_MAX)) begin
			res_s4.pixel_out <= PIX_MAX;
		end else begin
			res_s4.pixel_out <= total[PIX_W-1:0];
		end
	end

	assign push      = tag_s4.valid;
	assign push_data = res_s4;

endmodule

[rtl/core/c3s_out_fifo.sv]
// Result queue with credit count covering results still in the pipeline.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module c3s_out_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          reserve,
	input  logic          push,
	input  c3s_pkg::res_t push_data,
	output logic          room,
	c3s_res_if.source     res
);
	import c3s_pkg::*;

	logic [FIFO_CNT_W-1:0] cred_q, cnt_q;
	logic [FIFO_PTR_W-1:0] wr_q, rd_q;
	res_t                  ent_q [FIFO_DEPTH];
	logic                  pop;

	assign pop           = res.valid && res.ready;
	assign res.valid     = (cnt_q != '0);
	assign res.pixel_out = ent_q[rd_q].pixel_out;
	assign res.frame_end = ent_q[rd_q].frame_end;

	// a word is admitted only if its result has a slot waiting
	assign room = (cred_q < FIFO_CNT_W'(FIFO_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cred_q <= '0;
			cnt_q  <= '0;
			wr_q   <= '0;
			rd_q   <= '0;
		end else begin
			case ({reserve, pop})
				2'b10:   cred_q <= cred_q + 1'b1;
				2'b01:   cred_q <= cred_q - 1'b1;
				default: cred_q <= cred_q;
			endcase
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
			if (push) begin
				wr_q <= (wr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_data;
		end
	end

	`ASSERT_CLK(a_cred_covers, clk, arst_n, cred_q >= cnt_q, "queue holds more than was reserved")
	`ASSERT_IMPL(a_no_ovf, clk, arst_n, push && !pop, cnt_q < FIFO_CNT_W'(FIFO_DEPTH), "full queue")
	`ASSERT_IMPL(a_pop_credit, clk, arst_n, pop, cred_q != '0, "pop without reservation")

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the 3x3 saturating convolution stream core.
`timescale 1ns / 1ps
module tb_top;
	import c3s_pkg::*;

	localparam int LINE_MAX     = 1024;
	localparam int DRAIN_CYCLES = 12;
	localparam int CFG_IDX_LAST = (1 << CFG_IDX_W) - 1;
	localparam int RANDOM_ITEMS = 300;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	c3s_cfg_if cfg_ch ();
	c3s_pix_if pix_ch ();
	c3s_res_if res_ch ();

	conv3x3_saturating_stream dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.pix    (pix_ch),
		.res    (res_ch)
	);

	always #5 clk = ~clk;

	// shadow of the block: registers, line memory, window and counters
	logic [REG_W-1:0]     krow [TAPS];
	logic [DIM_REG_W-1:0] width_reg;
	logic [DIM_REG_W-1:0] lines_reg;
	pix_t                 line_mem [2*LINE_MAX];
	pix_t                 win_mem [6];
	int                   col_cnt;
	int                   row_cnt;

	res_t expected_px [$];
	int   err_count      = 0;
	int   pixels_sent    = 0;
	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;

	function automatic int clamp_dim(logic [DIM_REG_W-1:0] v, int hi);
		if (v < MIN_DIM)
			return int'(MIN_DIM);
		if (int'(v) > hi)
			return hi;
		return int'(v);
	endfunction

	function automatic void shadow_reset();
		krow[0]   = KROW0_RST;
		krow[1]   = KROW1_RST;
		krow[2]   = KROW2_RST;
		width_reg = DIM_RST;
		lines_reg = DIM_RST;
		foreach (line_mem[i])
			line_mem[i] = '0;
		foreach (win_mem[i])
			win_mem[i] = '0;
		col_cnt = 0;
		row_cnt = 0;
	endfunction

	function automatic void shadow_reg_write(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] d);
		case (idx)
			REG_KERNEL_ROW0: krow[0] = d;
			REG_KERNEL_ROW1: krow[1] = d;
			REG_KERNEL_ROW2: krow[2] = d;
			REG_LINE_WIDTH:  width_reg = d[DIM_REG_W-1:0];
			REG_FRAME_LINES: lines_reg = d[DIM_REG_W-1:0];
			default: ;
		endcase
	endfunction

	// One accepted pixel: convolve the window if it is complete, then shift
	function automatic void convolve_pixel(pix_t p);
		int                      w;
		int                      h;
		int                      col;
		pix_t                    top;
		pix_t                    mid;
		pix_t                    nb [TAPS][TAPS];
		logic [31:0]             acc;
		logic [COEF_FIELD_W-1:0] coef;
		res_t                    r;
		w   = clamp_dim(width_reg, LINE_MAX);
		h   = clamp_dim(lines_reg, LINE_MAX);
		col = col_cnt % LINE_MAX;
		mid = line_mem[col];
		top = line_mem[LINE_MAX + col];
		for (int y = 0; y < TAPS; y++) begin
			nb[y][0] = win_mem[y];
			nb[y][1] = win_mem[3 + y];
		end
		nb[0][2] = top;
		nb[1][2] = mid;
		nb[2][2] = p;

		if (row_cnt >= 2 && col_cnt >= 2) begin
			acc = '0;
			for (int y = 0; y < TAPS; y++)
				for (int x = 0; x < TAPS; x++) begin
					coef = krow[y][COEF_FIELD_W*x +: COEF_FIELD_W];
					acc  = acc + 32'(nb[y][x]) * 32'(coef);
				end
			r.pixel_out = (acc > 32'(PIX_MAX)) ? PIX_MAX : acc[PIX_W-1:0];
			r.frame_end = (row_cnt == h - 1) && (col_cnt == w - 1);
			expected_px.push_back(r);
		end

		win_mem[0] = win_mem[3];
		win_mem[1] = win_mem[4];
		win_mem[2] = win_mem[5];
		win_mem[3] = top;
		win_mem[4] = mid;
		win_mem[5] = p;
		line_mem[LINE_MAX + col] = mid;
		line_mem[col]            = p;

		col_cnt++;
		if (col_cnt >= w) begin
			col_cnt = 0;
			row_cnt++;
			if (row_cnt >= h)
				row_cnt = 0;
		end else if (row_cnt >= h) begin
			row_cnt = 0;
		end
	endfunction

	function automatic logic [REG_W-1:0] rand_kernel_row(int style);
		logic [REG_W-1:0] k;
		k = '0;
		for (int x = 0; x < TAPS; x++)
			case (style)
				0: k[COEF_FIELD_W*x +: COEF_FIELD_W] =
					($urandom_range(9) < 7) ? 0 : $urandom_range(2, 1);
				1: k[COEF_FIELD_W*x +: COEF_FIELD_W] = $urandom_range(65535);
				default: k[COEF_FIELD_W*x +: COEF_FIELD_W] = $urandom_range(1);
			endcase
		return k;
	endfunction

	// drive defaults before the first edge
	initial begin
		cfg_ch.valid    = 1'b0;
		cfg_ch.index    = '0;
		cfg_ch.data     = '0;
		pix_ch.valid    = 1'b0;
		pix_ch.pixel_in = '0;
		res_ch.ready    = 1'b0;
	end

	// result side back-pressure
	always @(negedge clk)
		res_ch.ready = ($urandom_range(99) >= recv_stall_pct);

	// compare each result word against the oldest expected pixel
	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_px.size() == 0) begin
				$error("unexpected result: pixel_out=%0d frame_end=%0b",
					res_ch.pixel_out, res_ch.frame_end);
				err_count++;
			end else begin
				want = expected_px.pop_front();
				if (res_ch.pixel_out !== want.pixel_out) begin
					$error("pixel_out: expected %0d, got %0d", want.pixel_out,
						res_ch.pixel_out);
					err_count++;
				end
				if (res_ch.frame_end !== want.frame_end) begin
					$error("frame_end: expected %0b, got %0b", want.frame_end,
						res_ch.frame_end);
					err_count++;
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

	task automatic set_idling(int send_pct, int recv_pct);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	// offer one pixel word and wait for it to be taken
	task automatic send_pixel(pix_t p);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			pix_ch.valid = 1'b0;
			@(negedge clk);
		end
		pix_ch.valid    = 1'b1;
		pix_ch.pixel_in = p;
		do
			@(posedge clk);
		while (pix_ch.ready !== 1'b1);
		convolve_pixel(p);
		pixels_sent++;
	endtask

	task automatic send_pixels(int count, int pmax);
		for (int i = 0; i < count; i++)
			send_pixel(pix_t'($urandom_range(pmax)));
	endtask

	// stop sending and let every outstanding result come out
	task automatic wait_drain();
		@(negedge clk);
		pix_ch.valid = 1'b0;
		while (expected_px.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] d);
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data  = d;
		do
			@(posedge clk);
		while (cfg_ch.ready !== 1'b1);
		shadow_reg_write(idx, d);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// complete the frame in progress, drain, then load a full setting
	task automatic configure(logic [REG_W-1:0] k0, logic [REG_W-1:0] k1,
		logic [REG_W-1:0] k2, logic [REG_W-1:0] w, logic [REG_W-1:0] h);
		while (col_cnt != 0 || row_cnt != 0)
			send_pixel(pix_t'($urandom_range(255)));
		wait_drain();
		write_reg(REG_KERNEL_ROW0, k0);
		write_reg(REG_KERNEL_ROW1, k1);
		write_reg(REG_KERNEL_ROW2, k2);
		write_reg(REG_LINE_WIDTH, w);
		write_reg(REG_FRAME_LINES, h);
	endtask

	// identity kernel and full line width as left by reset; an oversized
	// width written mid-line clamps back to the same full width
	task automatic test_reset_defaults();
		logic [REG_W-1:0] hi_bits;
		hi_bits = {REG_W{1'b1}} << DIM_REG_W;
		set_idling(0, 0);
		send_pixels(LINE_MAX / 2, 255);
		wait_drain();
		write_reg(REG_LINE_WIDTH, hi_bits | (LINE_MAX + 1));
		send_pixels(LINE_MAX + LINE_MAX / 2 + 8, 255);
		wait_drain();
		// shrink the frame so that it closes on the next pixel
		write_reg(REG_FRAME_LINES, 3);
		write_reg(REG_LINE_WIDTH, 3);
	endtask

	// saturation, zero result and every coefficient position
	task automatic test_kernel_directed();
		set_idling(0, 0);
		configure({REG_W{1'b1}}, {REG_W{1'b1}}, {REG_W{1'b1}}, 3, 3);
		for (int i = 0; i < 9; i++)
			send_pixel(PIX_MAX);
		configure({REG_W{1'b1}}, {REG_W{1'b1}}, {REG_W{1'b1}}, 3, 3);
		for (int i = 0; i < 9; i++)
			send_pixel('0);
		configure(48'h0003_0002_0001, 48'h0006_0005_0004, 48'h0009_0008_0007, 4, 3);
		send_pixels(12, 3);
	endtask

	// out-of-range geometry is clamped; upper data bits are dropped
	task automatic test_geometry_clamp();
		logic [REG_W-1:0] hi_bits;
		hi_bits = {REG_W{1'b1}} << DIM_REG_W;
		set_idling(21, 21);
		configure(48'h1, 48'h10000, 48'h1_0000_0000, 0, 2);
		send_pixels(9, 80);
		// tallest frame: no frame end over the first rows
		set_idling(69, 0);
		configure(rand_kernel_row(2), 48'h10000, rand_kernel_row(0),
			hi_bits | 1, hi_bits | 11'h7FF);
		send_pixels(30, 28);
		wait_drain();
		write_reg(REG_FRAME_LINES, 3);
		set_idling(0, 69);
		configure(rand_kernel_row(0), rand_kernel_row(0), rand_kernel_row(0),
			hi_bits | 4, hi_bits | 1);
		send_pixels(24, 255);
	endtask

	// writes to unused indexes leave every register alone
	task automatic test_unknown_index();
		set_idling(21, 21);
		configure(rand_kernel_row(2), rand_kernel_row(2), rand_kernel_row(2), 5, 4);
		for (int i = int'(REG_FRAME_LINES) + 1; i <= CFG_IDX_LAST; i++)
			write_reg(CFG_IDX_W'(i), REG_W'({$urandom, $urandom}));
		send_pixels(20, 31);
	endtask

	// geometry changes take effect at once, counters past the limit wrap
	task automatic test_midframe_geometry();
		set_idling(21, 21);
		configure(48'h1, 48'h10000, 48'h1_0000_0000, 8, 3);
		// stop on the last line, past the narrowed last column
		send_pixels(21, 80);
		wait_drain();
		write_reg(REG_LINE_WIDTH, 4);
		send_pixels(9, 80);
		wait_drain();
		write_reg(REG_FRAME_LINES, 6);
		send_pixels(12, 80);
		wait_drain();
		// row now beyond the new height
		write_reg(REG_FRAME_LINES, 3);
		send_pixels(10, 80);
	endtask

	// random frames with random kernels, partial frames and idling phases
	task automatic test_random_frames();
		int start;
		int ep;
		int w;
		int h;
		int pmax;
		int style;
		start = pixels_sent;
		ep    = 0;
		while (pixels_sent - start < RANDOM_ITEMS) begin
			case (ep % 4)
				0: set_idling(0, 0);
				1: set_idling(69, 0);
				2: set_idling(0, 69);
				default: set_idling(21, 21);
			endcase
			w = ($urandom_range(9) == 0) ? $urandom_range(40, 3) : $urandom_range(12, 3);
			h = $urandom_range(8, 3);
			case ($urandom_range(2))
				0: pmax = 255;
				1: pmax = 31;
				default: pmax = 7;
			endcase
			style = $urandom_range(2);
			configure(rand_kernel_row(style), rand_kernel_row(style),
				rand_kernel_row(style), w, h);
			if ($urandom_range(99) < 15) begin
				// narrow the line and change the height part-way through
				send_pixels($urandom_range(w * h - 1, 1), pmax);
				wait_drain();
				write_reg(REG_LINE_WIDTH, $urandom_range(w, 3));
				write_reg(REG_FRAME_LINES, $urandom_range(10, 3));
				send_pixels($urandom_range(2 * w * h, 1), pmax);
			end else begin
				send_pixels(w * h * $urandom_range(2, 1), pmax);
			end
			ep++;
		end
	endtask

	initial begin
		shadow_reset();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_kernel_directed();
		test_geometry_clamp();
		test_unknown_index();
		test_midframe_geometry();
		test_random_frames();

		wait_drain();
		if (err_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/c3s_pkg.sv
rtl/core/c3s_if.sv
rtl/core/c3s_line_buf.sv
rtl/core/c3s_mac.sv
rtl/core/c3s_out_fifo.sv
rtl/core/conv3x3_saturating_stream.sv
tb/tb_top.sv
